// File: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// concurrent check on the block clock and reset
`define ASSERT_ON(label, prop) \
    `ASSERT_CLK(label, i_clk, i_rst_n, prop)

`endif

// File: hdl/plar_pkg.sv
// types and constants of the polyline arc-length resampler
package plar_pkg;

    localparam int COORD_W     = 32;
    localparam int LEN_W       = 34;
    localparam int TOT_W       = 42;
    localparam int ALPHA_BITS  = 30;
    localparam int DIV_W       = 64;
    localparam int CNT_W       = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [CNT_W-1:0] COUNT_RESET = 6'd16;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FEW  = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    typedef struct packed {
        logic        final_pt;
        logic [31:0] pz;
        logic [31:0] py;
        logic [31:0] px;
    } t_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [LEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [LEN_W-1:0] rem;
    } t_div_rsp;

endpackage

// File: hdl/plar_ram.sv
// generic simple dual-port ram with registered read
module plar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/plar_front.sv
// input side: accepts point words into a short queue for the back end
module plar_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  plar_pkg::t_item i_item,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output plar_pkg::t_item o_q_item
);
    import plar_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic                push;
    logic                pop;

    assign o_ready   = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: hdl/plar_div.sv
// iterative restoring divider, one quotient bit per cycle
module plar_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plar_pkg::t_div_req i_req,
    output plar_pkg::t_div_rsp o_rsp
);
    import plar_pkg::*;

    localparam int SW = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [SW-1:0]    r_step;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_quo;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_den;
    logic [LEN_W:0]   shifted;
    logic [LEN_W:0]   diff;
    logic             ge;

    assign shifted = {r_rem, r_num[DIV_W-1]};
    assign ge      = (shifted >= {1'b0, r_den});
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_rem <= ge ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SW'(DIV_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule

// File: hdl/plar_back.sv
// back end: stores points, measures segments, walks the arc and interpolates
module plar_back #(
    parameter int MAX_POINTS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [plar_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                        i_q_valid,
    output logic                        o_q_ready,
    input  plar_pkg::t_item             i_q_item,
    output plar_pkg::t_div_req          o_div_req,
    input  plar_pkg::t_div_rsp          i_div_rsp,
    output logic                        o_m_valid,
    input  logic                        i_m_ready,
    output logic [95:0]                 o_m_data,
    output logic                        o_m_last,
    output logic [1:0]                  o_m_user
);
    import plar_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQ    = 5'd1;
    localparam logic [4:0] S_ROOT  = 5'd2;
    localparam logic [4:0] S_SEGW  = 5'd3;
    localparam logic [4:0] S_RUN   = 5'd4;
    localparam logic [4:0] S_QGO   = 5'd5;
    localparam logic [4:0] S_QWAIT = 5'd6;
    localparam logic [4:0] S_RDSEG = 5'd7;
    localparam logic [4:0] S_CHK   = 5'd8;
    localparam logic [4:0] S_AGO   = 5'd9;
    localparam logic [4:0] S_RDA   = 5'd10;
    localparam logic [4:0] S_RDB   = 5'd11;
    localparam logic [4:0] S_AWAIT = 5'd12;
    localparam logic [4:0] S_MUL   = 5'd13;
    localparam logic [4:0] S_ADD   = 5'd14;
    localparam logic [4:0] S_EMIT  = 5'd15;

    function automatic logic [31:0] lane(input logic [95:0] v, input logic [1:0] k);
        logic [31:0] r;
        case (k)
            2'd0:    r = v[31:0];
            2'd1:    r = v[63:32];
            2'd2:    r = v[95:64];
            default: r = v[31:0];
        endcase
        return r;
    endfunction

    logic [4:0]       r_state;
    logic [CNT_W-1:0] r_rcount;
    logic [CW-1:0]    r_count;
    logic [TOT_W-1:0] r_total;
    logic [95:0]      r_prev;
    logic [95:0]      r_last;
    t_item            r_item;
    logic [1:0]       r_k;
    logic [67:0]      r_sum;
    logic [67:0]      r_sq_s;
    logic [LEN_W-1:0] r_root;
    logic [36:0]      r_srem;
    logic [5:0]       r_step;
    logic [CNT_W-1:0] r_cnt;
    logic [TOT_W-1:0] r_q;
    logic [CNT_W-1:0] r_r;
    logic [TOT_W-1:0] r_sacc;
    logic [CNT_W-1:0] r_racc;
    logic [CNT_W-1:0] r_i;
    logic [AW-1:0]    r_j;
    logic [TOT_W-1:0] r_c;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_arem;
    logic [95:0]      r_pa;
    logic [95:0]      r_pb;
    logic [30:0]      r_alpha;
    logic [63:0]      r_prod;
    logic             r_neg;
    logic [31:0]      r_p0;
    logic [95:0]      r_res;
    logic             r_res_last;
    logic [1:0]       r_res_status;
    logic             r_ovalid;
    logic [95:0]      r_odata;
    logic             r_olast;
    logic [1:0]       r_ouser;

    logic             pt_we;
    logic [AW-1:0]    pt_raddr;
    logic [95:0]      pt_rdata;
    logic             seg_we;
    logic [AW-1:0]    seg_raddr;
    logic [LEN_W-1:0] seg_rdata;
    logic             full;
    logic             pop;
    logic [CW-1:0]    nseg;

    logic [31:0]      sq_a;
    logic [31:0]      sq_b;
    logic [32:0]      sq_d;
    logic [32:0]      sq_m;
    logic [65:0]      sq;
    logic [67:0]      n_sum;
    logic [36:0]      rt_sh;
    logic [36:0]      rt_trial;
    logic             rt_ge;
    logic [TOT_W:0]   walk_end;
    logic [TOT_W-1:0] walk_rem;
    logic [LEN_W-1:0] walk_clamp;
    logic [31:0]      lp_a;
    logic [31:0]      lp_b;
    logic [32:0]      lp_d;
    logic [32:0]      lp_m;
    logic [63:0]      lp_round;
    logic [33:0]      lp_off;
    logic [33:0]      lp_res;
    logic [CNT_W:0]   n_racc;
    logic             load_out;

    assign full      = (r_count >= CW'(MAX_POINTS));
    assign o_q_ready = (r_state == S_IDLE);
    assign pop       = i_q_valid && o_q_ready;
    assign nseg      = r_count - 1'b1;
    assign pt_we     = pop && !full;
    assign seg_we    = (r_state == S_SEGW);
    assign seg_raddr = r_j;
    assign pt_raddr  = (r_state == S_RDA) ? r_j + 1'b1 : r_j;

    plar_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_q_item.pz, i_q_item.py, i_q_item.px}),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    plar_ram #(.WIDTH(LEN_W), .DEPTH(MAX_POINTS)) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (AW'(nseg)),
        .i_wdata (r_root),
        .i_raddr (seg_raddr),
        .o_rdata (seg_rdata)
    );

    // squared coordinate difference, one axis per cycle
    always_comb begin
        sq_a  = lane(r_prev, r_k);
        sq_b  = lane({r_item.pz, r_item.py, r_item.px}, r_k);
        sq_d  = {sq_b[31], sq_b} - {sq_a[31], sq_a};
        sq_m  = sq_d[32] ? (~sq_d + 1'b1) : sq_d;
        sq    = sq_m * sq_m;
        n_sum = r_sum + {2'b0, sq};
    end

    // digit-by-digit square root, one root bit per cycle
    always_comb begin
        rt_sh    = {r_srem[34:0], r_sq_s[67:66]};
        rt_trial = {1'b0, r_root, 2'b01};
        rt_ge    = (rt_sh >= rt_trial);
    end

    always_comb begin
        walk_end   = {1'b0, r_c} + {{(TOT_W-LEN_W+1){1'b0}}, seg_rdata};
        walk_rem   = (r_sacc > r_c) ? r_sacc - r_c : '0;
        walk_clamp = (walk_rem > {{(TOT_W-LEN_W){1'b0}}, seg_rdata})
                   ? seg_rdata : walk_rem[LEN_W-1:0];
    end

    always_comb begin
        lp_a     = lane(r_pa, r_k);
        lp_b     = lane(r_pb, r_k);
        lp_d     = {lp_b[31], lp_b} - {lp_a[31], lp_a};
        lp_m     = lp_d[32] ? (~lp_d + 1'b1) : lp_d;
        lp_round = r_prod + (64'd1 << (ALPHA_BITS - 1));
        lp_off   = lp_round[63:30];
        lp_res   = r_neg ? ({{2{r_p0[31]}}, r_p0} - lp_off) : ({{2{r_p0[31]}}, r_p0} + lp_off);
        n_racc   = {1'b0, r_racc} + {1'b0, r_r};
    end

    always_comb begin
        o_div_req.start = (r_state == S_QGO) || (r_state == S_AGO);
        if (r_state == S_QGO) begin
            o_div_req.num = {{(DIV_W-TOT_W){1'b0}}, r_total};
            o_div_req.den = {{(LEN_W-CNT_W){1'b0}}, r_cnt};
        end else begin
            o_div_req.num = {r_arem, {ALPHA_BITS{1'b0}}};
            o_div_req.den = r_len;
        end
    end

    assign load_out = (r_state == S_EMIT) && (!r_ovalid || i_m_ready);

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_odata <= r_res;
            r_olast <= r_res_last;
            r_ouser <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rcount <= COUNT_RESET;
            r_count  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_rcount <= i_cfg_wdata;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_item <= i_q_item;
                        if (!full && r_count != '0) begin
                            r_k     <= '0;
                            r_sum   <= '0;
                            r_state <= S_SQ;
                        end else begin
                            if (!full) begin
                                r_count <= r_count + 1'b1;
                                r_prev  <= {i_q_item.pz, i_q_item.py, i_q_item.px};
                                r_last  <= {i_q_item.pz, i_q_item.py, i_q_item.px};
                            end
                            if (i_q_item.final_pt) begin
                                r_state <= S_RUN;
                            end
                        end
                    end
                end
                S_SQ: begin
                    r_sum <= n_sum;
                    r_k   <= r_k + 1'b1;
                    if (r_k == 2'd2) begin
                        r_sq_s  <= n_sum;
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_step  <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_sq_s <= {r_sq_s[65:0], 2'b00};
                    if (rt_ge) begin
                        r_srem <= rt_sh - rt_trial;
                        r_root <= {r_root[LEN_W-2:0], 1'b1};
                    end else begin
                        r_srem <= rt_sh;
                        r_root <= {r_root[LEN_W-2:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 6'(LEN_W - 1)) begin
                        r_state <= S_SEGW;
                    end
                end
                S_SEGW: begin
                    r_total <= r_total + {{(TOT_W-LEN_W){1'b0}}, r_root};
                    r_count <= r_count + 1'b1;
                    r_prev  <= {r_item.pz, r_item.py, r_item.px};
                    r_last  <= {r_item.pz, r_item.py, r_item.px};
                    r_state <= r_item.final_pt ? S_RUN : S_IDLE;
                end
                S_RUN: begin
                    r_res      <= '0;
                    r_res_last <= 1'b1;
                    if (r_count < CW'(2)) begin
                        r_res_status <= STATUS_FEW;
                        r_state      <= S_EMIT;
                    end else if (r_total == '0) begin
                        r_res_status <= STATUS_ZERO;
                        r_state      <= S_EMIT;
                    end else begin
                        r_cnt   <= (r_rcount == '0) ? CNT_W'(1) : r_rcount;
                        r_state <= S_QGO;
                    end
                end
                S_QGO: begin
                    r_state <= S_QWAIT;
                end
                S_QWAIT: begin
                    if (i_div_rsp.done) begin
                        r_q     <= i_div_rsp.quo[TOT_W-1:0];
                        r_r     <= i_div_rsp.rem[CNT_W-1:0];
                        r_sacc  <= '0;
                        r_racc  <= '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_c     <= '0;
                        r_state <= S_RDSEG;
                    end
                end
                S_RDSEG: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (CW'(r_j) >= nseg) begin
                        // sample past the last segment: clamp to last point
                        r_res        <= r_last;
                        r_res_status <= STATUS_OK;
                        r_res_last   <= (r_i == r_cnt);
                        r_state      <= S_EMIT;
                    end else if (seg_rdata == '0 || walk_end < {1'b0, r_sacc}) begin
                        r_c     <= walk_end[TOT_W-1:0];
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RDSEG;
                    end else begin
                        r_len   <= seg_rdata;
                        r_arem  <= walk_clamp;
                        r_state <= S_AGO;
                    end
                end
                S_AGO: begin
                    r_state <= S_RDA;
                end
                S_RDA: begin
                    r_pa    <= pt_rdata;
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_pb    <= pt_rdata;
                    r_state <= S_AWAIT;
                end
                S_AWAIT: begin
                    if (i_div_rsp.done) begin
                        r_alpha <= i_div_rsp.quo[30:0];
                        r_k     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= lp_m * r_alpha;
                    r_neg   <= lp_d[32];
                    r_p0    <= lane(r_pa, r_k);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    case (r_k)
                        2'd0:    r_res[31:0]  <= lp_res[31:0];
                        2'd1:    r_res[63:32] <= lp_res[31:0];
                        default: r_res[95:64] <= lp_res[31:0];
                    endcase
                    if (r_k == 2'd2) begin
                        r_res_status <= STATUS_OK;
                        r_res_last   <= (r_i == r_cnt);
                        r_state      <= S_EMIT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_EMIT: begin
                    if (load_out) begin
                        if (r_res_last) begin
                            r_count <= '0;
                            r_total <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            // next arc position: quotient step plus carried remainder
                            r_i <= r_i + 1'b1;
                            if (n_racc >= {1'b0, r_cnt}) begin
                                r_racc <= CNT_W'(n_racc - {1'b0, r_cnt});
                                r_sacc <= r_sacc + r_q + 1'b1;
                            end else begin
                                r_racc <= n_racc[CNT_W-1:0];
                                r_sacc <= r_sacc + r_q;
                            end
                            r_state <= S_RDSEG;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_valid = r_ovalid;
    assign o_m_data  = r_odata;
    assign o_m_last  = r_olast;
    assign o_m_user  = r_ouser;
endmodule

// File: hdl/polyline_arc_length_resampler_unit.sv
// top level of the polyline arc-length resampler
//
// channel  dir  width  contents
// s_axis   in   96+1   point x,y,z (tdata), final point (tlast)
// m_axis   out  96+1+2 resampled x,y,z (tdata), run end (tlast), status (tuser)
// cfg      in   6      resample count, written when i_cfg_wen is high
//
// each stored point: three squared axis differences summed, then a 34-step square root
// a run starts with a division of the total length by the sample count; each sample
// then walks the segments and interpolates, using the shared 64-step divider
// reset sets counts, totals and state only; point and length rams need no clearing pass
// a 4-word queue takes input while the back end works; one output register holds a word
module polyline_arc_length_resampler_unit #(
    parameter int MAX_POINTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // pos_x, pos_y, pos_z
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // out_x, out_y, out_z
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // status
);
    import plar_pkg::*;
`include "assert_macros.svh"

    t_item    in_item;
    t_item    q_item;
    logic     q_valid;
    logic     q_ready;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign in_item.px       = s_axis_tdata[31:0];
    assign in_item.py       = s_axis_tdata[63:32];
    assign in_item.pz       = s_axis_tdata[95:64];
    assign in_item.final_pt = s_axis_tlast;

    plar_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    plar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    plar_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (m_axis_tdata),
        .o_m_last    (m_axis_tlast),
        .o_m_user    (m_axis_tuser)
    );

    `ASSERT_ON(a_err_is_last, m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tlast)
    `ASSERT_ON(a_err_zero, m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tdata == '0)
    `ASSERT_CLK(a_status_code, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_FEW || m_axis_tuser == STATUS_ZERO))
endmodule
